// ----- rtl/lla_pkg.sv -----
// Shared types and constants for the least-loaded node allocator.
package lla_pkg;

  localparam int KEY_W    = 64;
  localparam int COUNT_W  = 10;
  localparam int LOAD_W   = 16;
  localparam int AGE_W    = 32;
  localparam int CFG_W    = 3;
  localparam int NODE_O_W = 2;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic               mode;
    logic [COUNT_W-1:0] request_count;
    logic [KEY_W-1:0]   client_key;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [NODE_O_W-1:0] chosen_node;
    logic [LOAD_W-1:0]   node_load;
  } rsp_t;

endpackage

// ----- rtl/least_loaded_node_allocator.sv -----
// Least-loaded node allocator: record table and node usage in synchronous memories.
// Each request passes the scan, load-read and finish states; finish waits while a held result
//   is stalled, and the result is registered. One transaction is in flight at a time, as each
//   needs a full pass over the single read port of the record memory.
// Reset: synchronous; a clearing pass over max(RECORD_SLOTS, MAX_NODES) addresses then wipes
//   both memories, with no request taken until it ends.
module least_loaded_node_allocator #(
  parameter int MAX_NODES    = 4,
  parameter int RECORD_SLOTS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  lla_pkg::req_t            req,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output lla_pkg::rsp_t            rsp,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [lla_pkg::CFG_W-1:0] cfg_data
);
  import lla_pkg::*;

  localparam int SCAN_LEN = (RECORD_SLOTS > MAX_NODES) ? RECORD_SLOTS : MAX_NODES;
  localparam int CW = $clog2(SCAN_LEN + 1);
  localparam int AW = $clog2(RECORD_SLOTS);
  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_LREAD  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [NW-1:0]      node;
    logic [COUNT_W-1:0] amount;
    logic [AGE_W-1:0]   age;
  } rec_t;

  rec_t              rec_mem [RECORD_SLOTS];
  logic [LOAD_W-1:0] load_mem [MAX_NODES];

  logic [2:0]        state;
  logic [CW-1:0]     cnt;
  logic [CFG_W-1:0]  node_count;
  logic [CW-1:0]     n_act;
  req_t              req_q;
  logic [AGE_W-1:0]  age_counter;

  rec_t              rec_q;
  logic [LOAD_W-1:0] load_q;

  logic              found_free;
  logic [AW-1:0]     free_slot;
  logic [NW-1:0]     best;
  logic [LOAD_W-1:0] best_load;
  logic              hit;
  logic [AW-1:0]     hit_slot;
  logic [NW-1:0]     hit_node;
  logic [COUNT_W-1:0] hit_amt;
  logic [AGE_W-1:0]  best_diff;

  logic [AW-1:0]     rec_ra;
  logic [NW-1:0]     load_ra;
  logic              rec_we;
  logic [AW-1:0]     rec_wa;
  rec_t              rec_wd;
  logic              load_we;
  logic [NW-1:0]     load_wa;
  logic [LOAD_W-1:0] load_wd;

  logic [CW-1:0]     scan_p;
  logic              scan_ld;
  logic              scan_rc;
  logic              key_match;
  logic [AGE_W-1:0]  rec_diff;
  logic [CW-1:0]     n_next;
  logic [NW-1:0]     op_node;
  logic [NW+1:0]     op_node_ext;
  logic [LOAD_W:0]   sum;
  logic [LOAD_W-1:0] rel_load;
  logic              fin_go;
  rsp_t              rsp_next;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    if (node_count == '0) begin
      n_next = CW'(1);
    end else if (int'(node_count) > MAX_NODES) begin
      n_next = CW'(MAX_NODES);
    end else begin
      n_next = CW'(node_count);
    end
  end

  assign scan_p    = cnt - CW'(1);
  assign scan_ld   = (state == S_SCAN) && (cnt != '0) && (scan_p < n_act);
  assign scan_rc   = (state == S_SCAN) && (cnt != '0) && (scan_p < CW'(RECORD_SLOTS));
  assign key_match = rec_q.valid && (rec_q.key == req_q.client_key);
  assign rec_diff  = age_counter - rec_q.age;

  assign op_node     = (req_q.mode == MODE_RELEASE) ? hit_node : best;
  assign op_node_ext = {2'b00, op_node};
  assign sum         = {1'b0, load_q} + (LOAD_W + 1)'(req_q.request_count);
  assign rel_load    = (load_q >= LOAD_W'(hit_amt)) ? (load_q - LOAD_W'(hit_amt)) : '0;
  assign fin_go      = (state == S_FINISH) && (!rsp_valid || !rsp_stall);

  // Read addresses
  always_comb begin
    rec_ra  = '0;
    load_ra = op_node;
    if (state == S_SCAN) begin
      if (cnt < CW'(RECORD_SLOTS)) rec_ra = cnt[AW-1:0];
      load_ra = (cnt < CW'(MAX_NODES)) ? cnt[NW-1:0] : '0;
    end
  end

  // Write ports and result
  always_comb begin
    rec_we   = 1'b0;
    rec_wa   = '0;
    rec_wd   = '0;
    load_we  = 1'b0;
    load_wa  = op_node;
    load_wd  = '0;
    rsp_next = '0;
    case (state)
      S_CLEAR: begin
        rec_we  = (cnt < CW'(RECORD_SLOTS));
        rec_wa  = cnt[AW-1:0];
        load_we = (cnt < CW'(MAX_NODES));
        load_wa = cnt[NW-1:0];
      end
      S_FINISH: begin
        rsp_next.chosen_node = op_node_ext[1:0];
        rsp_next.node_load   = load_q;
        if (req_q.mode == MODE_ALLOC) begin
          if (!found_free) begin
            rsp_next.status = ST_FULL;
          end else if (sum[LOAD_W]) begin
            rsp_next.status = ST_OVERFLOW;
          end else begin
            rsp_next.status    = ST_OK;
            rsp_next.node_load = sum[LOAD_W-1:0];
            load_we      = fin_go;
            load_wd      = sum[LOAD_W-1:0];
            rec_we       = fin_go;
            rec_wa       = free_slot;
            rec_wd.valid = 1'b1;
            rec_wd.key   = req_q.client_key;
            rec_wd.node  = best;
            rec_wd.amount = req_q.request_count;
            rec_wd.age   = age_counter;
          end
        end else begin
          if (!hit) begin
            rsp_next.status      = ST_NOT_FOUND;
            rsp_next.chosen_node = '0;
            rsp_next.node_load   = '0;
          end else begin
            rsp_next.status    = ST_OK;
            rsp_next.node_load = rel_load;
            load_we = fin_go;
            load_wd = rel_load;
            rec_we  = fin_go;
            rec_wa  = hit_slot;
            rec_wd  = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec_q  <= rec_mem[rec_ra];
    load_q <= load_mem[load_ra];
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (load_we) load_mem[load_wa] <= load_wd;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      cnt         <= '0;
      node_count  <= CFG_W'(1);
      age_counter <= '0;
      rsp_valid   <= 1'b0;
      found_free  <= 1'b0;
      hit         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) node_count <= cfg_data;
      if (rsp_valid && !rsp_stall && !fin_go) rsp_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (cnt == CW'(SCAN_LEN - 1)) begin
            state <= S_IDLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            req_q      <= req;
            n_act      <= n_next;
            found_free <= 1'b0;
            hit        <= 1'b0;
            cnt        <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_ld && (scan_p == '0 || load_q < best_load)) begin
            best      <= scan_p[NW-1:0];
            best_load <= load_q;
          end
          if (scan_rc) begin
            if (req_q.mode == MODE_ALLOC) begin
              if (!rec_q.valid && !found_free) begin
                found_free <= 1'b1;
                free_slot  <= scan_p[AW-1:0];
              end
            end else if (key_match && (!hit || rec_diff < best_diff)) begin
              hit       <= 1'b1;
              hit_slot  <= scan_p[AW-1:0];
              hit_node  <= rec_q.node;
              hit_amt   <= rec_q.amount;
              best_diff <= rec_diff;
            end
          end
          if (cnt == CW'(SCAN_LEN)) begin
            state <= S_LREAD;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_LREAD: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (fin_go) begin
            rsp_valid <= 1'b1;
            rsp       <= rsp_next;
            state     <= S_IDLE;
            if (req_q.mode == MODE_ALLOC && found_free && !sum[LOAD_W]) begin
              age_counter <= age_counter + AGE_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/lla_checker.sv -----
// Port-level assertions for the least-loaded node allocator, with bind.
module lla_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input lla_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input lla_pkg::rsp_t rsp
);
  import lla_pkg::*;

  // held result stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while busy");

  // a new result comes only from a request in progress
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !$past(rsp_valid) && !$past(rst) |-> $past(req_stall))
    else $error("result without request");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_NOT_FOUND |-> rsp.chosen_node == '0 && rsp.node_load == '0)
    else $error("not-found result carries data");

endmodule

bind least_loaded_node_allocator lla_checker u_lla_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
